@@ hw/rtl/skpc_pkg.sv @@
// Package for the streaming KMP pattern counter.
// Holds request codes, port widths and the memory control bundle.
// Used by skpc_store.sv, streaming_kmp_pattern_counter.sv and the testbench files.
package skpc_pkg;

  localparam int REQ_W = 2;
  localparam int SYM_W = 8;
  localparam int OUT_COUNT_W = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W = OUT_TDATA_W - OUT_COUNT_W - 2;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEXT = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic pat_we;
    logic bor_we;
  } mem_ctl_t;

endpackage

@@ hw/rtl/streaming_kmp_pattern_counter.sv @@
// Streaming KMP pattern counter: counts overlapping pattern occurrences in a byte stream.
// Clear, a rejected append, an append to an empty pattern, a text byte on an empty pattern
// and unused codes answer from idle through the output register, one transaction per cycle unless the output stalls.
// Other appends and text bytes read the pattern and border memories and pass through the scan
// state, with one more border-memory read for each failure link followed; no new item is taken meanwhile.
// Reset (rst_n low, synchronous) empties the pattern and zeroes count; memories are not swept.
module streaming_kmp_pattern_counter #(
  parameter int MAX_PATTERN = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [skpc_pkg::SYM_W-1:0]        in_tdata,   // symbol
  input  logic [skpc_pkg::REQ_W-1:0]        in_tuser,   // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [skpc_pkg::OUT_TDATA_W-1:0]  out_tdata   // match_found, match_count, pattern_full
);

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PW = $clog2(MAX_PATTERN + 1);
  localparam logic [PW-1:0] LEN_MAX = PW'(MAX_PATTERN);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  state_t                          state_r, state_nxt;
  logic [PW-1:0]                   len_r, len_nxt;
  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [PW-1:0]                   lastb_r, lastb_nxt;
  logic [PW-1:0]                   j_r, j_nxt;
  logic [COUNT_WIDTH-1:0]          count_r, count_nxt;
  logic [skpc_pkg::SYM_W-1:0]      sym_r, sym_nxt;
  logic                            append_r, append_nxt;
  logic                            res_found_r, res_found_nxt;
  logic                            res_full_r, res_full_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_found_r, out_found_nxt;
  logic                            out_full_r, out_full_nxt;
  logic [skpc_pkg::OUT_COUNT_W-1:0] out_count_r, out_count_nxt;

  skpc_pkg::mem_ctl_t              mem_ctl;
  logic [PW-1:0]                   rd_j;
  logic [PW-1:0]                   rd_jm1;
  logic [skpc_pkg::SYM_W-1:0]      pat_rdata;
  logic [PW-1:0]                   bor_rdata;
  logic [PW-1:0]                   bor_wdata;
  logic [63:0]                     cnt_ext;
  logic [COUNT_WIDTH-1:0]          count_inc;
  logic                            slot_free;
  logic                            hit;
  logic [PW-1:0]                   jn;

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = {{skpc_pkg::OUT_PAD_W{1'b0}}, out_full_r, out_count_r, out_found_r};

  assign slot_free = !out_valid_r || out_tready;
  assign count_inc = (count_r == {COUNT_WIDTH{1'b1}}) ? count_r : count_r + 1'b1;
  assign cnt_ext = 64'(count_nxt);
  assign rd_jm1 = rd_j - 1'b1;
  assign hit = (pat_rdata == sym_r);
  assign jn = j_r + PW'(hit);

  skpc_store #(
    .DEPTH (MAX_PATTERN),
    .AW    (AW),
    .BW    (PW)
  ) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .pat_waddr (len_r[AW-1:0]),
    .pat_wdata (in_tdata),
    .bor_waddr (len_r[AW-1:0]),
    .bor_wdata (bor_wdata),
    .pat_raddr (rd_j[AW-1:0]),
    .bor_raddr (rd_jm1[AW-1:0]),
    .pat_rdata (pat_rdata),
    .bor_rdata (bor_rdata)
  );

  always_comb begin
    logic emit;
    logic emit_found;
    logic emit_full;
    emit = 1'b0;
    emit_found = 1'b0;
    emit_full = 1'b0;
    state_nxt = state_r;
    len_nxt = len_r;
    pos_nxt = pos_r;
    lastb_nxt = lastb_r;
    j_nxt = j_r;
    count_nxt = count_r;
    sym_nxt = sym_r;
    append_nxt = append_r;
    res_found_nxt = res_found_r;
    res_full_nxt = res_full_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_full_nxt = out_full_r;
    out_count_nxt = out_count_r;
    mem_ctl = '0;
    rd_j = pos_r;
    bor_wdata = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sym_nxt = in_tdata;
          case (in_tuser)
            skpc_pkg::REQ_CLEAR: begin
              len_nxt = '0;
              pos_nxt = '0;
              count_nxt = '0;
              emit = 1'b1;
            end
            skpc_pkg::REQ_APPEND: begin
              if (len_r == LEN_MAX) begin
                emit = 1'b1;
                emit_full = 1'b1;
              end else begin
                mem_ctl.pat_we = 1'b1;
                if (len_r == '0) begin
                  mem_ctl.bor_we = 1'b1;
                  lastb_nxt = '0;
                  len_nxt = len_r + 1'b1;
                  pos_nxt = '0;
                  count_nxt = '0;
                  emit = 1'b1;
                end else begin
                  mem_ctl.rd_en = 1'b1;
                  rd_j = lastb_r;
                  j_nxt = lastb_r;
                  append_nxt = 1'b1;
                  state_nxt = ST_SCAN;
                end
              end
            end
            skpc_pkg::REQ_TEXT: begin
              if (len_r == '0) begin
                count_nxt = count_inc;
                emit = 1'b1;
                emit_found = 1'b1;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_j = pos_r;
                j_nxt = pos_r;
                append_nxt = 1'b0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
          if (emit && !slot_free) begin
            emit = 1'b0;
            res_found_nxt = emit_found;
            res_full_nxt = emit_full;
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_SCAN: begin
        rd_j = bor_rdata;
        if (!hit && (j_r != '0)) begin
          mem_ctl.rd_en = 1'b1;
          j_nxt = bor_rdata;
        end else if (slot_free) begin
          emit = 1'b1;
          state_nxt = ST_IDLE;
          if (append_r) begin
            mem_ctl.bor_we = 1'b1;
            bor_wdata = jn;
            lastb_nxt = jn;
            len_nxt = len_r + 1'b1;
            pos_nxt = '0;
            count_nxt = '0;
          end else if (jn == len_r) begin
            emit_found = 1'b1;
            count_nxt = count_inc;
            pos_nxt = lastb_r;
          end else begin
            pos_nxt = jn;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_found = res_found_r;
          emit_full = res_full_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = emit_found;
      out_full_nxt = emit_full;
      out_count_nxt = cnt_ext[skpc_pkg::OUT_COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r <= '0;
      pos_r <= '0;
      lastb_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      pos_r <= pos_nxt;
      lastb_r <= lastb_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    j_r <= j_nxt;
    sym_r <= sym_nxt;
    append_r <= append_nxt;
    res_found_r <= res_found_nxt;
    res_full_r <= res_full_nxt;
    out_found_r <= out_found_nxt;
    out_full_r <= out_full_nxt;
    out_count_r <= out_count_nxt;
  end

endmodule

@@ hw/rtl/skpc_store.sv @@
// Pattern and border table storage for the KMP pattern counter.
// Two synchronous memories with one write and one registered read port each.
// Depends on skpc_pkg for the control bundle.
module skpc_store #(
  parameter int DEPTH = 64,
  parameter int AW = 6,
  parameter int BW = 7
) (
  input  logic                        clk,
  input  skpc_pkg::mem_ctl_t          ctl,
  input  logic [AW-1:0]               pat_waddr,
  input  logic [skpc_pkg::SYM_W-1:0]  pat_wdata,
  input  logic [AW-1:0]               bor_waddr,
  input  logic [BW-1:0]               bor_wdata,
  input  logic [AW-1:0]               pat_raddr,
  input  logic [AW-1:0]               bor_raddr,
  output logic [skpc_pkg::SYM_W-1:0]  pat_rdata,
  output logic [BW-1:0]               bor_rdata
);

  logic [skpc_pkg::SYM_W-1:0] pat_mem [DEPTH];
  logic [BW-1:0]              bor_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.pat_we) begin
      pat_mem[pat_waddr] <= pat_wdata;
    end
    if (ctl.rd_en) begin
      pat_rdata <= pat_mem[pat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.bor_we) begin
      bor_mem[bor_waddr] <= bor_wdata;
    end
    if (ctl.rd_en) begin
      bor_rdata <= bor_mem[bor_raddr];
    end
  end

endmodule

@@ test/kmp_count_sb_pkg.sv @@
// Scoreboard for the streaming KMP pattern counter testbench.
// Predicts each result from the accepted requests and checks the result stream in order.
// Depends on skpc_pkg for request codes and output widths.
`timescale 1ns / 1ps
package kmp_count_sb_pkg;
  import skpc_pkg::*;

  localparam int PATTERN_DEPTH = 64;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic                   found;
    logic [OUT_COUNT_W-1:0] count;
    logic                   full;
  } kmp_answer_t;

  class kmp_count_tracker;
    logic [SYM_W-1:0]       pat_bytes[PATTERN_DEPTH];
    logic [6:0]             borders[PATTERN_DEPTH];
    int unsigned            pat_len;
    int unsigned            cur_pos;
    logic [OUT_COUNT_W-1:0] occ_count;
    kmp_answer_t            pending_answers[$];
    int unsigned            mismatches;
    int unsigned            checked;
    int unsigned            matches_seen;
    int unsigned            rejects_seen;

    function new();
      pat_len = 0;
      cur_pos = 0;
      occ_count = '0;
      mismatches = 0;
      checked = 0;
      matches_seen = 0;
      rejects_seen = 0;
    endfunction

    function void bump_occurrences();
      if (occ_count != '1) occ_count++;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [SYM_W-1:0] sym);
      kmp_answer_t ans;
      int k;
      int j;
      ans = '0;
      case (req)
        REQ_CLEAR: begin
          pat_len = 0;
          cur_pos = 0;
          occ_count = '0;
        end
        REQ_APPEND: begin
          if (pat_len >= PATTERN_DEPTH) begin
            ans.full = 1'b1;
          end else begin
            pat_bytes[pat_len] = sym;
            j = 0;
            if (pat_len > 0) begin
              k = borders[pat_len-1];
              while (1) begin
                if (pat_bytes[k] == sym) begin
                  j = k + 1;
                  break;
                end
                if (k == 0) break;
                k = borders[k-1];
              end
            end
            borders[pat_len] = 7'(j);
            pat_len++;
            cur_pos = 0;
            occ_count = '0;
          end
        end
        REQ_TEXT: begin
          if (pat_len == 0) begin
            bump_occurrences();
            ans.found = 1'b1;
          end else begin
            j = (cur_pos >= pat_len) ? 0 : cur_pos;
            while (j > 0 && pat_bytes[j] != sym) j = borders[j-1];
            if (pat_bytes[j] == sym) j++;
            if (j == pat_len) begin
              bump_occurrences();
              cur_pos = borders[pat_len-1];
              ans.found = 1'b1;
            end else begin
              cur_pos = j;
            end
          end
        end
        default: begin
        end
      endcase
      ans.count = occ_count;
      pending_answers.push_back(ans);
    endfunction

    function void compare_field(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      kmp_answer_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: result %h arrived with none expected", $time, data);
        mismatches++;
        return;
      end
      want = pending_answers.pop_front();
      checked++;
      compare_field("match_found", 64'(want.found), 64'(data[0]));
      compare_field("match_count", 64'(want.count), 64'(data[OUT_COUNT_W:1]));
      compare_field("pattern_full", 64'(want.full), 64'(data[OUT_COUNT_W+1]));
      compare_field("padding", 64'(0), 64'(data[OUT_TDATA_W-1:OUT_COUNT_W+2]));
      if (data[0] === 1'b1) matches_seen++;
      if (data[OUT_COUNT_W+1] === 1'b1) rejects_seen++;
    endfunction
  endclass

endpackage

@@ test/tb_streaming_kmp_pattern_counter.sv @@
// Top-level testbench for the streaming KMP pattern counter.
// Drives clear, append, text and unused-code transactions with random gaps and output stalls.
// Depends on skpc_pkg, kmp_count_sb_pkg and the counter RTL.
`timescale 1ns / 1ps
module tb_streaming_kmp_pattern_counter;
  import skpc_pkg::*;
  import kmp_count_sb_pkg::*;

  localparam int ITEM_TARGET = 1050;
  localparam int LONG_HOLD = 300;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [SYM_W-1:0]       in_tdata;
  logic [REQ_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  kmp_count_tracker tracker = new();
  int unsigned      items_sent = 0;
  int unsigned      burst_left = 0;
  bit               hold_wanted = 0;
  logic [SYM_W-1:0] cur_pat[$];
  logic [SYM_W-1:0] alphabet[3];
  int unsigned      alpha_size = 1;

  streaming_kmp_pattern_counter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL streaming_kmp_pattern_counter");
    $finish;
  end

  initial begin
    int unsigned hold_left;
    int unsigned phase_left;
    int unsigned stall_mode;
    int unsigned cyc;
    hold_left = 0;
    phase_left = 0;
    stall_mode = 0;
    cyc = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_wanted) begin
        hold_wanted = 0;
        hold_left = LONG_HOLD;
      end
      if (phase_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ((cyc % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  task automatic push_request(logic [REQ_W-1:0] req, logic [SYM_W-1:0] sym);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= sym;
    do @(posedge clk); while (!in_tready);
    tracker.note_request(req, sym);
    items_sent++;
    if (req == REQ_CLEAR) cur_pat.delete();
    else if (req == REQ_APPEND && cur_pat.size() < PATTERN_DEPTH) cur_pat.push_back(sym);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic pick_alphabet();
    alpha_size = $urandom_range(1, 3);
    foreach (alphabet[i]) alphabet[i] = SYM_W'($urandom_range(0, 255));
  endtask

  task automatic build_pattern(int unsigned len);
    repeat (len) push_request(REQ_APPEND, alphabet[$urandom_range(0, alpha_size - 1)]);
  endtask

  task automatic text_run(int unsigned len);
    logic [SYM_W-1:0] copy[$];
    int unsigned n;
    n = 0;
    while (n < len) begin
      if (cur_pat.size() != 0 && $urandom_range(0, 3) == 0) begin
        copy = cur_pat;
        foreach (copy[i]) push_request(REQ_TEXT, copy[i]);
        n += copy.size();
      end else begin
        push_request(REQ_TEXT, alphabet[$urandom_range(0, alpha_size - 1)]);
        n++;
      end
    end
  endtask

  initial begin
    int unsigned pick;
    bit held;
    held = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_CLEAR;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    push_request(REQ_TEXT, 8'h00);
    push_request(REQ_TEXT, 8'hFF);
    push_request(REQ_UNUSED, 8'hFF);
    push_request(REQ_UNUSED, 8'h00);
    push_request(REQ_CLEAR, 8'h00);
    push_request(REQ_APPEND, 8'hFF);
    push_request(REQ_APPEND, 8'h00);
    push_request(REQ_APPEND, 8'hFF);
    push_request(REQ_TEXT, 8'hFF);
    push_request(REQ_TEXT, 8'h00);
    push_request(REQ_TEXT, 8'hFF);
    push_request(REQ_TEXT, 8'h00);
    push_request(REQ_TEXT, 8'hFF);
    push_request(REQ_UNUSED, 8'h5A);
    push_request(REQ_APPEND, 8'h00);
    push_request(REQ_TEXT, 8'h00);
    push_request(REQ_CLEAR, 8'hFF);
    push_request(REQ_TEXT, 8'h55);
    push_request(REQ_APPEND, 8'hAA);
    push_request(REQ_TEXT, 8'hAA);
    push_request(REQ_TEXT, 8'hAA);
    push_request(REQ_TEXT, 8'h55);

    pick_alphabet();
    push_request(REQ_CLEAR, 8'h00);
    build_pattern(PATTERN_DEPTH + 3);
    text_run(48);
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (!held && items_sent >= 400) begin
        held = 1;
        hold_wanted = 1;
        burst_left = 60;
      end
      pick_alphabet();
      if (pick < 70) begin
        if ($urandom_range(0, 4) != 0) push_request(REQ_CLEAR, SYM_W'($urandom_range(0, 255)));
        build_pattern(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6));
        text_run($urandom_range(8, 48));
      end else if (pick < 85) begin
        repeat ($urandom_range(4, 16))
          push_request(REQ_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        push_request(REQ_CLEAR, SYM_W'($urandom_range(0, 255)));
        text_run($urandom_range(2, 10));
      end else if (pick < 97) begin
        push_request(REQ_CLEAR, SYM_W'($urandom_range(0, 255)));
        build_pattern(PATTERN_DEPTH + $urandom_range(0, 3));
        text_run(40);
      end else begin
        drain_results();
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    $display("Sent %0d transactions and checked %0d results in order.",
             items_sent, tracker.checked);
    $display("Results carried %0d matches and %0d rejected appends on a full pattern.",
             tracker.matches_seen, tracker.rejects_seen);
    if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
      $display("PASS streaming_kmp_pattern_counter");
    end else begin
      $display("FAIL streaming_kmp_pattern_counter");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/skpc_pkg.sv
hw/rtl/skpc_store.sv
hw/rtl/streaming_kmp_pattern_counter.sv
test/kmp_count_sb_pkg.sv
test/tb_streaming_kmp_pattern_counter.sv
